### rtl/gif_lzw_decoder_assert.svh
// assertion macros for the gif lzw decoder
// expects i_clk and i_rst_n in the scope of each use
`ifndef GIF_LZW_DECODER_ASSERT_SVH
`define GIF_LZW_DECODER_ASSERT_SVH

// condition holds at every edge out of reset
`define GLD_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// trigger implies condition in the next cycle
`define GLD_IMPLY(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### rtl/gld_pkg.sv
// shared types and constants of the gif lzw decoder
// no dependencies
`default_nettype none

package gld_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int ACC_W             = 20;
    localparam int BITS_W            = 5;
    localparam int SIZE_W            = 4;
    localparam logic [SIZE_W-1:0] RESET_MIN_SIZE = 4'd8;
    localparam logic [SIZE_W-1:0] MIN_SIZE_LO    = 4'd2;
    localparam logic [SIZE_W-1:0] MIN_SIZE_HI    = 4'd8;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_FEED  = 2'd1,
        CMD_FETCH = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_WALK,
        S_WAIT,
        S_UPD,
        S_POPCHK,
        S_POP,
        S_RESP
    } t_state;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        if (v < MIN_SIZE_LO) begin
            return MIN_SIZE_LO;
        end else if (v > MIN_SIZE_HI) begin
            return MIN_SIZE_HI;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/gld_ram.sv
// simple dual port synchronous ram, one write and one registered read port
// no dependencies
`default_nettype none

module gld_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/gif_lzw_decoder.sv
// gif variable-width lzw decoder top level: control sequencer and state registers
// depends on gld_pkg, gld_ram and gif_lzw_decoder_assert.svh
// usage
//   request channel s_axis: tuser carries the command (start, feed, fetch, no-op),
//   tdata the compressed byte for feed. one response per request on m_axis:
//   tdata is the pixel index, tuser the flags accepted, index_valid, finished, error.
//   feed is refused (accepted low) while a whole code is already buffered;
//   fetch the pixels out and then retry the byte.
//   a fetch on an empty stack with a whole code buffered decodes one code: a string
//   is walked from its last pixel back through the dictionary ram, one pixel pushed
//   per cycle, then the entry is added and the first pixel popped.
// steps from the accepting edge to the response in the output register
//   start, feed, no-op: response state, then output register.
//   fetch from a filled stack: fetch, pop check, pop (registered stack ram read), response.
//   fetch that decodes a string: the walk reads the dictionary ram once per pixel,
//   then update, pop check, pop, response; the rest of the string pops one per fetch.
// one request at a time; the next is taken once the response sits in the output
// register, which holds it while m_axis_tready is low.
// reset: minimum code size 8, empty dictionary, stack and bit buffer; rams not cleared.
// i_cfg_wr_en/i_cfg_wr_data set the minimum code size used by the next start.
`default_nettype none
`include "gif_lzw_decoder_assert.svh"

module gif_lzw_decoder #(
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [3:0] i_cfg_wr_data,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0] s_axis_tuser,   // [1:0] cmd
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] pixel_index
    output logic [3:0]      m_axis_tuser    // [0] accepted [1] index_valid [2] finished [3] error
);

    localparam int MB     = MAX_CODE_BITS;
    localparam int ACC_W  = gld_pkg::ACC_W;
    localparam int BITS_W = gld_pkg::BITS_W;
    localparam int SIZE_W = gld_pkg::SIZE_W;
    localparam logic [MB:0] LIMIT = (MB+1)'(1) << MB;

    gld_pkg::t_state r_state, n_state;

    logic [SIZE_W-1:0] r_min, r_size, n_size;
    logic [MB:0]       r_nfc, n_nfc;
    logic [3:0]        r_cb, n_cb;
    logic [MB-1:0]     r_prev, n_prev;
    logic              r_prev_valid, n_prev_valid;
    logic [7:0]        r_first, n_first;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [BITS_W-1:0] r_bits, n_bits;
    logic [MB:0]       r_level, n_level;
    logic              r_done, n_done;
    logic              r_err, n_err;
    logic [MB-1:0]     r_c, n_c;          // walk pointer
    logic [MB-1:0]     r_code, n_code;    // code being decoded
    logic [7:0]        r_new_first, n_new_first;
    logic              r_res_acc, n_res_acc;
    logic              r_res_valid, n_res_valid;
    logic [7:0]        r_res_pix, n_res_pix;
    logic              r_out_valid;
    logic [7:0]        r_out_pix;
    logic [3:0]        r_out_flags;

    // dictionary and stack ports
    logic              w_dict_we;
    logic [MB-1:0]     w_dict_raddr;
    logic [MB+7:0]     w_dict_rdata;
    logic [MB-1:0]     w_prefix;
    logic [7:0]        w_suffix;
    logic              w_stk_we;
    logic [7:0]        w_stk_wdata;
    logic [MB-1:0]     w_stk_raddr;
    logic [7:0]        w_stk_rdata;

    logic              w_accept;
    gld_pkg::t_cmd     w_cmd;
    logic [MB:0]       w_pow, w_clear, w_code_ext, w_c_ext, w_prefix_ext;
    logic [MB-1:0]     w_code;
    logic              w_can_decode, w_is_clear, w_is_end, w_bad_first, w_over, w_kwk;
    logic              w_push_ok, w_out_load;
    logic [SIZE_W-1:0] w_start_size;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = gld_pkg::t_cmd'(s_axis_tuser);
    assign s_axis_tready = (r_state == gld_pkg::S_IDLE);

    assign w_pow        = (MB+1)'(1) << r_cb;
    assign w_code       = r_acc[MB-1:0] & MB'(w_pow - (MB+1)'(1));
    assign w_code_ext   = {1'b0, w_code};
    assign w_clear      = (MB+1)'(1) << r_size;
    assign w_can_decode = (r_level == '0) && !r_done && !r_err && (r_bits >= BITS_W'(r_cb));
    assign w_is_clear   = (w_code_ext == w_clear);
    assign w_is_end     = (w_code_ext == w_clear + (MB+1)'(1));
    assign w_bad_first  = w_code_ext > w_clear;
    assign w_over       = (w_code_ext > r_nfc) || ((w_code_ext == r_nfc) && (r_nfc >= LIMIT));
    assign w_kwk        = (w_code_ext == r_nfc);
    assign w_c_ext      = {1'b0, r_c};
    assign w_push_ok    = !r_level[MB];
    assign w_prefix     = w_dict_rdata[MB+7:8];
    assign w_suffix     = w_dict_rdata[7:0];
    assign w_prefix_ext = {1'b0, w_prefix};
    assign w_start_size = gld_pkg::clamp_size(r_min);
    assign w_out_load   = (r_state == gld_pkg::S_RESP) && (!r_out_valid || m_axis_tready);

    assign w_dict_raddr = (r_state == gld_pkg::S_WALK) ? r_c : w_prefix;
    assign w_stk_raddr  = MB'(r_level - (MB+1)'(1));

    gld_ram #(.ADDR_W(MB), .DATA_W(MB + 8)) u_dict (
        .i_clk   (i_clk),
        .i_we    (w_dict_we),
        .i_waddr (r_nfc[MB-1:0]),
        .i_wdata ({r_prev, r_new_first}),
        .i_raddr (w_dict_raddr),
        .o_rdata (w_dict_rdata)
    );

    gld_ram #(.ADDR_W(MB), .DATA_W(8)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (r_level[MB-1:0]),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gld_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_cmd == gld_pkg::CMD_FETCH) ? gld_pkg::S_FETCH
                                                           : gld_pkg::S_RESP;
                end
            end
            gld_pkg::S_FETCH: begin
                if (w_can_decode && !w_is_clear && !w_is_end && r_prev_valid && !w_over) begin
                    n_state = gld_pkg::S_WALK;
                end else begin
                    n_state = gld_pkg::S_POPCHK;
                end
            end
            gld_pkg::S_WALK: begin
                n_state = (w_c_ext >= w_clear) ? gld_pkg::S_WAIT : gld_pkg::S_UPD;
            end
            gld_pkg::S_WAIT: begin
                n_state = (w_prefix_ext >= w_clear) ? gld_pkg::S_WAIT : gld_pkg::S_WALK;
            end
            gld_pkg::S_UPD:    n_state = gld_pkg::S_POPCHK;
            gld_pkg::S_POPCHK: begin
                n_state = (r_level != '0) ? gld_pkg::S_POP : gld_pkg::S_RESP;
            end
            gld_pkg::S_POP:    n_state = gld_pkg::S_RESP;
            gld_pkg::S_RESP: begin
                if (w_out_load) begin
                    n_state = gld_pkg::S_IDLE;
                end
            end
            default:           n_state = gld_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_size       = r_size;
        n_nfc        = r_nfc;
        n_cb         = r_cb;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_first      = r_first;
        n_acc        = r_acc;
        n_bits       = r_bits;
        n_level      = r_level;
        n_done       = r_done;
        n_err        = r_err;
        n_c          = r_c;
        n_code       = r_code;
        n_new_first  = r_new_first;
        n_res_acc    = r_res_acc;
        n_res_valid  = r_res_valid;
        n_res_pix    = r_res_pix;
        w_dict_we    = 1'b0;
        w_stk_we     = 1'b0;
        w_stk_wdata  = w_suffix;

        unique case (r_state)
            gld_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_res_acc   = 1'b0;
                    n_res_valid = 1'b0;
                    n_res_pix   = '0;
                    unique case (w_cmd)
                        gld_pkg::CMD_START: begin
                            n_size       = w_start_size;
                            n_nfc        = ((MB+1)'(1) << w_start_size) + (MB+1)'(2);
                            n_cb         = w_start_size + 4'd1;
                            n_prev_valid = 1'b0;
                            n_prev       = '0;
                            n_first      = '0;
                            n_acc        = '0;
                            n_bits       = '0;
                            n_level      = '0;
                            n_done       = 1'b0;
                            n_err        = 1'b0;
                        end
                        gld_pkg::CMD_FEED: begin
                            if (r_bits < BITS_W'(r_cb)) begin
                                n_acc     = r_acc | (ACC_W'(s_axis_tdata) << r_bits);
                                n_bits    = r_bits + BITS_W'(8);
                                n_res_acc = 1'b1;
                            end
                        end
                        gld_pkg::CMD_FETCH, gld_pkg::CMD_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            gld_pkg::S_FETCH: begin
                if (w_can_decode) begin
                    n_acc  = r_acc >> r_cb;
                    n_bits = r_bits - BITS_W'(r_cb);
                    n_code = w_code;
                    if (w_is_clear) begin
                        n_nfc        = w_clear + (MB+1)'(2);
                        n_cb         = r_size + 4'd1;
                        n_prev_valid = 1'b0;
                        n_prev       = '0;
                    end else if (w_is_end) begin
                        n_done = 1'b1;
                    end else if (!r_prev_valid) begin
                        if (w_bad_first) begin
                            n_err = 1'b1;
                        end else begin
                            // literal: stack is empty here
                            w_stk_we     = 1'b1;
                            w_stk_wdata  = w_code[7:0];
                            n_level      = r_level + (MB+1)'(1);
                            n_first      = w_code[7:0];
                            n_prev       = w_code;
                            n_prev_valid = 1'b1;
                        end
                    end else if (w_over) begin
                        n_err = 1'b1;
                    end else begin
                        // known code: walk its string; kwkwk: string of previous code plus its first pixel
                        if (w_kwk) begin
                            w_stk_we    = 1'b1;
                            w_stk_wdata = r_first;
                            n_level     = r_level + (MB+1)'(1);
                        end
                        n_c = w_kwk ? r_prev : w_code;
                    end
                end
            end
            gld_pkg::S_WALK: begin
                if (w_c_ext < w_clear) begin
                    w_stk_wdata = r_c[7:0];
                    w_stk_we    = w_push_ok;
                    if (w_push_ok) begin
                        n_level = r_level + (MB+1)'(1);
                    end
                    n_new_first = r_c[7:0];
                end
            end
            gld_pkg::S_WAIT: begin
                w_stk_wdata = w_suffix;
                w_stk_we    = w_push_ok;
                if (w_push_ok) begin
                    n_level = r_level + (MB+1)'(1);
                end
                n_c = w_prefix;
            end
            gld_pkg::S_UPD: begin
                if (r_nfc < LIMIT) begin
                    w_dict_we = 1'b1;
                    n_nfc     = r_nfc + (MB+1)'(1);
                    if ((r_nfc + (MB+1)'(1) == w_pow) && (r_cb < 4'(MB))) begin
                        n_cb = r_cb + 4'd1;
                    end
                end
                n_first = r_new_first;
                n_prev  = r_code;
            end
            gld_pkg::S_POPCHK: begin
                if (r_level != '0) begin
                    n_level = r_level - (MB+1)'(1);
                end
            end
            gld_pkg::S_POP: begin
                n_res_pix   = w_stk_rdata;
                n_res_valid = 1'b1;
            end
            gld_pkg::S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gld_pkg::S_IDLE;
            r_min        <= gld_pkg::RESET_MIN_SIZE;
            r_size       <= gld_pkg::RESET_MIN_SIZE;
            r_nfc        <= ((MB+1)'(1) << gld_pkg::RESET_MIN_SIZE) + (MB+1)'(2);
            r_cb         <= gld_pkg::RESET_MIN_SIZE + 4'd1;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_first      <= '0;
            r_acc        <= '0;
            r_bits       <= '0;
            r_level      <= '0;
            r_done       <= 1'b0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_wr_en) begin
                r_min <= i_cfg_wr_data;
            end
            r_size       <= n_size;
            r_nfc        <= n_nfc;
            r_cb         <= n_cb;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_first      <= n_first;
            r_acc        <= n_acc;
            r_bits       <= n_bits;
            r_level      <= n_level;
            r_done       <= n_done;
            r_err        <= n_err;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_c         <= n_c;
        r_code      <= n_code;
        r_new_first <= n_new_first;
        r_res_acc   <= n_res_acc;
        r_res_valid <= n_res_valid;
        r_res_pix   <= n_res_pix;
        if (w_out_load) begin
            r_out_pix   <= r_res_pix;
            r_out_flags <= {r_err, r_done, r_res_valid, r_res_acc};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tuser  = r_out_flags;

    `GLD_CHECK(a_level_cap, r_level <= LIMIT, "stack level beyond stack depth")
    `GLD_CHECK(a_code_width, (r_cb >= 4'd3) && (r_cb <= 4'(MB)), "code width out of range")
    `GLD_IMPLY(a_one_request, w_accept, !s_axis_tready, "second request taken while busy")
    `GLD_IMPLY(a_resp_after_pop, r_state == gld_pkg::S_POP, r_res_valid, "pop lost its pixel")

endmodule

`default_nettype wire

### verif/gif_lzw_decoder_test.sv
// self-checking bench for the gif lzw decoder: a behavioral decoder predicts every
// response, stimulus is built from encoded gif code streams plus random noise
// depends on gld_pkg and gif_lzw_decoder
`timescale 1ns / 100ps

module gif_lzw_decoder_test;

    typedef struct packed {
        gld_pkg::t_cmd cmd;
        logic [7:0]    data;
    } t_request;

    typedef struct packed {
        logic       accepted;
        logic       index_valid;
        logic [7:0] pixel;
        logic       finished;
        logic       error;
    } t_response;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [3:0] i_cfg_wr_data = 4'd0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic [1:0] s_axis_tuser = 2'd0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;

    gif_lzw_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // ---------------- decoder predictor ----------------
    logic [11:0] pf_tab [4096];
    logic [7:0]  sf_tab [4096];
    logic [7:0]  pix_stack [4096];
    int unsigned next_code, width, prev_code, stack_top, accum, held;
    int unsigned size_reg, size_live;
    bit          prev_ok, done_f, err_f;
    logic [7:0]  first_pix;

    function automatic int unsigned clamp_min_size(int unsigned v);
        return v < 2 ? 2 : (v > 8 ? 8 : v);
    endfunction

    function automatic void table_restart();
        next_code = (1 << size_live) + 2;
        width     = size_live + 1;
        prev_ok   = 1'b0;
        prev_code = 0;
    endfunction

    function automatic void image_restart();
        size_live = clamp_min_size(size_reg);
        table_restart();
        first_pix = 8'd0;
        accum = 0; held = 0; stack_top = 0;
        done_f = 1'b0; err_f = 1'b0;
    endfunction

    function automatic void push_pix(logic [7:0] p);
        if (stack_top < 4096) begin
            pix_stack[stack_top] = p;
            stack_top++;
        end
    endfunction

    function automatic logic [7:0] push_chain(int unsigned c, int unsigned clr);
        int unsigned n;
        n = 0;
        c = c & 4095;
        while (c >= clr && n < 4096) begin
            push_pix(sf_tab[c]);
            c = pf_tab[c];
            n++;
        end
        push_pix(c[7:0]);
        return c[7:0];
    endfunction

    function automatic void decode_code();
        int unsigned clr, code;
        logic [7:0] head;
        clr   = 1 << size_live;
        code  = accum & ((1 << width) - 1);
        accum = (accum >> width) & 20'hFFFFF;
        held -= width;
        if (code == clr) begin
            table_restart();
            return;
        end
        if (code == clr + 1) begin
            done_f = 1'b1;
            return;
        end
        if (!prev_ok) begin
            if (code > clr) begin
                err_f = 1'b1;
                return;
            end
            first_pix = code[7:0];
            push_pix(code[7:0]);
            prev_code = code;
            prev_ok = 1'b1;
            return;
        end
        if (code > next_code || (code == next_code && next_code >= 4096)) begin
            err_f = 1'b1;
            return;
        end
        if (code == next_code) begin
            push_pix(first_pix);     // kwkwk: string is previous plus its own head
            head = push_chain(prev_code, clr);
        end else begin
            head = push_chain(code, clr);
        end
        if (next_code < 4096) begin
            pf_tab[next_code] = prev_code[11:0];
            sf_tab[next_code] = head;
            next_code++;
            if (next_code == (1 << width) && width < 12) width++;
        end
        first_pix = head;
        prev_code = code;
    endfunction

    function automatic t_response predict_response(t_request r);
        t_response rsp;
        rsp = '0;
        case (r.cmd)
            gld_pkg::CMD_START: image_restart();
            gld_pkg::CMD_FEED: begin
                if (held < width) begin
                    accum = (accum | (int'(r.data) << held)) & 20'hFFFFF;
                    held += 8;
                    rsp.accepted = 1'b1;
                end
            end
            gld_pkg::CMD_FETCH: begin
                if (stack_top == 0 && !done_f && !err_f && held >= width) decode_code();
                if (stack_top > 0) begin
                    stack_top--;
                    rsp.pixel = pix_stack[stack_top];
                    rsp.index_valid = 1'b1;
                end
            end
            default: ;
        endcase
        rsp.finished = done_f;
        rsp.error = err_f;
        return rsp;
    endfunction

    // ---------------- stimulus side ----------------
    // the predictor runs at generation time: a refused feed is simply retried
    // after a fetch, so the generated stream is exactly what the block sees
    t_request  pending_reqs [$];
    t_response expected_rsps [$];
    int        fail_count = 0;
    int        send_idle_pct = 0, recv_stall_pct = 0;
    bit        hold_recv = 1'b0;

    function automatic void queue_req(gld_pkg::t_cmd c, logic [7:0] d);
        t_request r;
        r.cmd = c;
        r.data = d;
        pending_reqs.push_back(r);
        expected_rsps.push_back(predict_response(r));
    endfunction

    // pack codes lsb first into the byte stream
    logic [7:0] enc_bytes [$];
    function automatic void pack_codes(ref int unsigned codes[$], ref int unsigned widths[$]);
        int unsigned acc, nb;
        acc = 0; nb = 0;
        enc_bytes.delete();
        foreach (codes[i]) begin
            acc |= codes[i] << nb;
            nb += widths[i];
            while (nb >= 8) begin
                enc_bytes.push_back(acc[7:0]);
                acc >>= 8;
                nb -= 8;
            end
        end
        if (nb > 0) enc_bytes.push_back(acc[7:0]);
    endfunction

    // once end or error is seen nothing decodes, so buffered bits no longer drain
    function automatic void stream_image(bit drain);
        foreach (enc_bytes[i]) begin
            while (held >= width && !done_f && !err_f)
                queue_req(gld_pkg::CMD_FETCH, 8'($urandom));
            queue_req(gld_pkg::CMD_FEED, enc_bytes[i]);
            if ($urandom_range(0, 3) == 0) queue_req(gld_pkg::CMD_FETCH, 8'($urandom));
        end
        if (drain) begin
            while ((held >= width && !done_f && !err_f) || stack_top > 0)
                queue_req(gld_pkg::CMD_FETCH, 8'($urandom));
        end
        queue_req(gld_pkg::CMD_FETCH, 8'($urandom));
    endfunction

    // well-formed code stream: tracks an encoder-side dictionary size and width
    function automatic void build_image(int unsigned n_codes, bit with_end, bit with_bad);
        int unsigned codes[$], widths[$];
        int unsigned clr, nxt, w, sz, k;
        bit have_prev;
        sz = clamp_min_size(size_reg);
        clr = 1 << sz;
        nxt = clr + 2; w = sz + 1; have_prev = 0;
        codes.push_back(clr); widths.push_back(w);
        for (int i = 0; i < n_codes; i++) begin
            if (!have_prev) k = $urandom_range(0, clr - 1);
            else begin
                case ($urandom_range(0, 9))
                    0: k = nxt;                                   // kwkwk
                    1, 2, 3: k = $urandom_range(0, clr - 1);
                    default: k = $urandom_range(clr + 2, nxt > clr + 2 ? nxt - 1 : clr);
                endcase
                if (k == clr || k == clr + 1) k = 0;
                if (k == nxt && nxt >= 4096) k = 0;
            end
            if (i == n_codes / 2 && $urandom_range(0, 3) == 0) begin
                codes.push_back(clr); widths.push_back(w);   // mid-stream clear
                nxt = clr + 2; w = sz + 1; have_prev = 0;
                k = $urandom_range(0, clr - 1);
            end
            codes.push_back(k); widths.push_back(w);
            if (have_prev && nxt < 4096) begin
                nxt++;
                if (nxt == (1 << w) && w < 12) w++;
            end
            have_prev = 1;
        end
        if (with_bad) begin
            codes.push_back(nxt + 1 < (1 << w) ? nxt + 1 : (1 << w) - 1);
            widths.push_back(w);
        end
        if (with_end) begin
            codes.push_back(clr + 1); widths.push_back(w);
        end
        queue_req(gld_pkg::CMD_START, 8'($urandom));
        pack_codes(codes, widths);
        stream_image(1'b1);
    endfunction

    // waits until everything is answered plus a margin, then writes the register
    task automatic write_min_size(logic [3:0] v);
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        size_reg = v;
    endtask

    // ---------------- driver ----------------
    // the front of the queue is the request on the bus until it is accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_axis_tvalid) void'(pending_reqs.pop_front());
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= pending_reqs[0].cmd;
                    s_axis_tdata <= pending_reqs[0].data;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor and scoreboard ----------------
    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= !hold_recv && $urandom_range(0, 99) >= recv_stall_pct;
            if (m_axis_tvalid && m_axis_tready) begin
                t_response want;
                if (expected_rsps.size() == 0) begin
                    report_mismatch("response with no request", m_axis_tuser, 0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (m_axis_tuser[0] !== want.accepted)
                        report_mismatch("accepted", m_axis_tuser[0], want.accepted);
                    if (m_axis_tuser[1] !== want.index_valid)
                        report_mismatch("index_valid", m_axis_tuser[1], want.index_valid);
                    if (want.index_valid && m_axis_tdata !== want.pixel)
                        report_mismatch("pixel_index", m_axis_tdata, want.pixel);
                    if (m_axis_tuser[2] !== want.finished)
                        report_mismatch("finished", m_axis_tuser[2], want.finished);
                    if (m_axis_tuser[3] !== want.error)
                        report_mismatch("error", m_axis_tuser[3], want.error);
                end
            end
        end
    end

    // watchdog: cycles without any handshake on either side
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (i_rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    task automatic hold_receiver();
        hold_recv = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_recv = 1'b0;
    endtask

    initial begin
        int unsigned sizes[5] = '{2, 8, 0, 15, 5};
        int phase;
        size_reg = 8;
        image_restart();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: nop, fetch on empty, feed refusal, clear code, fetch short of a code
        queue_req(gld_pkg::CMD_NOP, 8'hFF);
        queue_req(gld_pkg::CMD_FETCH, 8'h00);
        queue_req(gld_pkg::CMD_FEED, 8'h00);
        queue_req(gld_pkg::CMD_FEED, 8'hFF);
        queue_req(gld_pkg::CMD_FEED, 8'hA5);     // refused, a full code is waiting
        queue_req(gld_pkg::CMD_FETCH, 8'h00);
        queue_req(gld_pkg::CMD_FETCH, 8'h00);
        queue_req(gld_pkg::CMD_FETCH, 8'h00);
        build_image(6, 1, 0);
        queue_req(gld_pkg::CMD_FEED, 8'h55);
        queue_req(gld_pkg::CMD_FETCH, 8'h00);    // after end nothing decodes

        for (phase = 0; phase < 5; phase++) begin
            write_min_size(sizes[phase][3:0]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (phase == 1) fork hold_receiver(); join_none
            while (pending_reqs.size() < 220) begin
                if ($urandom_range(0, 4) == 0) begin
                    t_request r;
                    r.cmd = gld_pkg::t_cmd'(2'($urandom_range(0, 3)));
                    if (r.cmd == gld_pkg::CMD_START && $urandom_range(0, 1))
                        r.cmd = gld_pkg::CMD_FEED;
                    queue_req(r.cmd, 8'($urandom));
                end else begin
                    build_image($urandom_range(3, 40), $urandom_range(0, 1),
                                $urandom_range(0, 5) == 0);
                end
            end
        end
        // a longer image at the smallest code size grows the code width several times
        write_min_size(4'd2);
        send_idle_pct = 0; recv_stall_pct = 0;
        build_image(40, 1, 0);

        while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/gld_pkg.sv
rtl/gld_ram.sv
rtl/gif_lzw_decoder.sv
verif/gif_lzw_decoder_test.sv
